// ----- sv/atan2mp_pkg.sv -----
// Shared constants, types and helpers for the atan2 polynomial pipeline.
package atan2mp_pkg;

  localparam int IN_WIDTH        = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int POLY_FRAC       = 16;
  localparam int QW              = POLY_FRAC + 1;  // ratio width, Q1.16
  localparam int OUT_W           = 16;
  localparam int ANG_W           = (ANGLE_FRAC_BITS + 3 > OUT_W) ? ANGLE_FRAC_BITS + 3 : OUT_W;

  // minimax coefficients, Q0.16 magnitudes
  localparam logic [QW-1:0] K0 = QW'(12243);
  localparam logic [QW-1:0] K1 = QW'(1628);
  localparam logic [QW-1:0] K2 = QW'(21767);
  localparam logic [QW-1:0] K3 = QW'(6167);

  // pi scaled by 2^32, rounded to nearest at the angle fraction bits
  localparam logic [63:0] PI_Q32   = 64'd13493037705;
  localparam int          PI_SHF   = 32 - ANGLE_FRAC_BITS;
  localparam logic [63:0] PI_FULL  = (PI_Q32 + (64'd1 << (PI_SHF - 1))) >> PI_SHF;
  localparam logic [63:0] PIH_FULL = (PI_Q32 + (64'd1 << PI_SHF)) >> (PI_SHF + 1);
  localparam logic [ANG_W-1:0] PI_ANG  = PI_FULL[ANG_W-1:0];
  localparam logic [ANG_W-1:0] PIH_ANG = PIH_FULL[ANG_W-1:0];

  // Q1.16 to angle fraction bits: round half up going down, shift going up
  localparam int RND_SH = (ANGLE_FRAC_BITS < POLY_FRAC) ? POLY_FRAC - ANGLE_FRAC_BITS : 0;
  localparam int UP_SH  = (ANGLE_FRAC_BITS > POLY_FRAC) ? ANGLE_FRAC_BITS - POLY_FRAC : 0;
  localparam logic [63:0] RND_HALF = (RND_SH > 0) ? (64'd1 << (RND_SH - 1)) : 64'd0;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic swap;   // |y| > |x|
    logic zero;   // both inputs zero
  } flags_t;

  typedef struct packed {
    logic [IN_WIDTH:0]   rem;
    logic [IN_WIDTH-1:0] mx;
    logic [QW-1:0]       quo;
    flags_t              fl;
  } div_t;

  function automatic logic [ANG_W-1:0] to_angle(input logic [QW-1:0] r);
    logic [63:0] w;
    w = {{(64-QW){1'b0}}, r};
    w = ((w + RND_HALF) >> RND_SH) << UP_SH;
    return w[ANG_W-1:0];
  endfunction

endpackage

// ----- sv/atan2mp_in_if.sv -----
// Input channel: one coordinate pair per transaction.
interface atan2mp_in_if;
  logic                                         valid;
  logic                                         ready;
  logic signed [atan2mp_pkg::IN_WIDTH-1:0]      x_coord;
  logic signed [atan2mp_pkg::IN_WIDTH-1:0]      y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

// ----- sv/atan2mp_out_if.sv -----
// Output channel: one angle per transaction.
interface atan2mp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [atan2mp_pkg::OUT_W-1:0]  angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

// ----- sv/atan2_minimax_polynomial_top.sv -----
// Four-quadrant atan2 by an odd minimax polynomial: pipelined top level.
//
// Takes one (x_coord, y_coord) pair per clock unless every stage is full and
// the output is stalled, and returns the angle in signed Q2.13 radians. The
// pipeline is the ratio divider, which resolves one quotient bit per stage
// (17 stages), plus two stages of magnitude and ordering, five of polynomial multiplies and two of quadrant
// reflection. Every stage holds its own valid bit and moves forward whenever
// the stage after it is empty or moving, so bubbles close up and a stalled
// output holds back only the stages that are full. Input (0,0) yields 0.
module atan2_minimax_polynomial_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  atan2mp_in_if.sink           in_i,
  atan2mp_out_if.source        out_o
);

  localparam int W      = atan2mp_pkg::IN_WIDTH;
  localparam int QW     = atan2mp_pkg::QW;
  localparam int PF     = atan2mp_pkg::POLY_FRAC;
  localparam int ANG_W  = atan2mp_pkg::ANG_W;
  localparam int ST_MAG = 0;
  localparam int ST_ORD = 1;
  localparam int ST_DV0 = 2;
  localparam int ST_PS  = ST_DV0 + QW;
  localparam int ST_PCQ = ST_PS + 1;
  localparam int ST_PPM = ST_PCQ + 1;
  localparam int ST_PN  = ST_PPM + 1;
  localparam int ST_PR  = ST_PN + 1;
  localparam int ST_REF = ST_PR + 1;
  localparam int ST_OUT = ST_REF + 1;
  localparam int NS     = ST_OUT + 1;

  // ---------------- stage control ----------------
  logic [NS-1:0] v_q, v_d, adv;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    v_d[0] = adv[0] ? in_i.valid : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = adv[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_i.ready  = adv[0];
  assign out_o.valid = v_q[ST_OUT];

  // ---------------- magnitudes ----------------
  logic [W-1:0]        ax_q, ay_q, ax_d, ay_d;
  logic                xneg_q, yneg_q;
  atan2mp_pkg::div_t   ord_q, ord_d;

  always_comb begin
    ax_d = in_i.x_coord[W-1] ? (~in_i.x_coord + 1'b1) : in_i.x_coord;
    ay_d = in_i.y_coord[W-1] ? (~in_i.y_coord + 1'b1) : in_i.y_coord;
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_MAG]) begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      xneg_q <= in_i.x_coord[W-1];
      yneg_q <= in_i.y_coord[W-1];
    end
  end

  // ---------------- ordering ----------------
  always_comb begin
    ord_d.fl.xneg = xneg_q;
    ord_d.fl.yneg = yneg_q;
    ord_d.fl.swap = ay_q > ax_q;
    ord_d.fl.zero = (ax_q == '0) && (ay_q == '0);
    ord_d.rem     = {1'b0, ord_d.fl.swap ? ax_q : ay_q};
    ord_d.mx      = ord_d.fl.swap ? ay_q : ax_q;
    ord_d.quo     = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_ORD]) begin
      ord_q <= ord_d;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  atan2mp_pkg::div_t dv_q [QW];
  atan2mp_pkg::div_t dv_d [QW];
  atan2mp_pkg::div_t dv_src [QW];

  always_comb begin
    logic [W:0] trial;
    logic       ge;
    dv_src[0] = ord_q;
    for (int i = 1; i < QW; i++) begin
      dv_src[i] = dv_q[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      // first step decides the integer bit, the rest shift the remainder
      trial     = (i == 0) ? dv_src[i].rem : {dv_src[i].rem[W-1:0], 1'b0};
      ge        = trial >= {1'b0, dv_src[i].mx};
      dv_d[i]     = dv_src[i];
      dv_d[i].rem = ge ? (trial - {1'b0, dv_src[i].mx}) : trial;
      dv_d[i].quo = {dv_src[i].quo[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QW; i++) begin
      if (adv[ST_DV0+i]) begin
        dv_q[i] <= dv_d[i];
      end
    end
  end

  // ---------------- polynomial ----------------
  logic [QW-1:0]        a1_q, s1_q;
  logic [QW-1:0]        a2_q, s2_q, c2_q, q2_q;
  logic [QW-1:0]        a3_q, s3_q, c3_q, p3_q, m3_q;
  logic [QW-1:0]        a4_q, c4_q, n4_q;
  logic [QW-1:0]        r5_q;
  logic [ANG_W-1:0]     g6_q, o_q;
  atan2mp_pkg::flags_t  fl1_q, fl2_q, fl3_q, fl4_q, fl5_q, fl6_q;

  logic [2*QW-1:0] pr_s, pr_c, pr_q, pr_p, pr_m, pr_t, pr_u;
  logic [ANG_W-1:0] g_ref, g_out;

  always_comb begin
    pr_s  = dv_q[QW-1].quo * dv_q[QW-1].quo;
    pr_c  = s1_q * a1_q;
    pr_q  = s1_q * s1_q;
    pr_p  = atan2mp_pkg::K1 * q2_q;
    pr_m  = atan2mp_pkg::K3 * q2_q;
    pr_t  = p3_q * s3_q;
    pr_u  = n4_q * c4_q;
    g_ref = atan2mp_pkg::to_angle(r5_q);
    if (fl5_q.swap) begin
      g_ref = atan2mp_pkg::PIH_ANG - g_ref;
    end
    g_out = g6_q;
    if (fl6_q.xneg) begin
      g_out = atan2mp_pkg::PI_ANG - g_out;
    end
    if (fl6_q.yneg) begin
      g_out = ~g_out + 1'b1;
    end
    if (fl6_q.zero) begin
      g_out = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_PS]) begin
      a1_q  <= dv_q[QW-1].quo;
      s1_q  <= pr_s[QW+PF-1:PF];
      fl1_q <= dv_q[QW-1].fl;
    end
    if (adv[ST_PCQ]) begin
      a2_q  <= a1_q;
      s2_q  <= s1_q;
      c2_q  <= pr_c[QW+PF-1:PF];
      q2_q  <= pr_q[QW+PF-1:PF];
      fl2_q <= fl1_q;
    end
    if (adv[ST_PPM]) begin
      a3_q  <= a2_q;
      s3_q  <= s2_q;
      c3_q  <= c2_q;
      p3_q  <= pr_p[QW+PF-1:PF] + atan2mp_pkg::K0;
      m3_q  <= pr_m[QW+PF-1:PF] + atan2mp_pkg::K2;
      fl3_q <= fl2_q;
    end
    if (adv[ST_PN]) begin
      a4_q  <= a3_q;
      c4_q  <= c3_q;
      n4_q  <= m3_q - pr_t[QW+PF-1:PF];
      fl4_q <= fl3_q;
    end
    if (adv[ST_PR]) begin
      r5_q  <= a4_q - pr_u[QW+PF-1:PF];
      fl5_q <= fl4_q;
    end
    if (adv[ST_REF]) begin
      g6_q  <= g_ref;
      fl6_q <= fl5_q;
    end
    if (adv[ST_OUT]) begin
      o_q   <= g_out;
    end
  end

  assign out_o.angle = o_q[atan2mp_pkg::OUT_W-1:0];

  // ---------------- assertions ----------------
  // input held off only when every stage is full and the output is stalled
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v_q == {NS{1'b1}}) && !out_o.ready)
    else $error("input stalled while pipeline has room");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_ORD] |-> ord_q.rem <= {1'b0, ord_q.mx})
    else $error("min/max ordering broken");

  a_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_PS-1] && !dv_q[QW-1].fl.zero |->
      (dv_q[QW-1].quo <= QW'(1 << PF)) && (dv_q[QW-1].rem < {1'b0, dv_q[QW-1].mx}))
    else $error("divider quotient or remainder out of range");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_OUT] |-> (o_q <= atan2mp_pkg::PI_ANG) ||
                    ((~o_q + 1'b1) <= atan2mp_pkg::PI_ANG))
    else $error("angle outside -pi..pi");

endmodule
